### src/kmce_pkg.sv
// kmce_pkg: shared sizes, result kinds and register indexes of the key
// matrix change encoder. No dependencies.
package kmce_pkg;

	localparam int ROWS           = 4;
	localparam int COLS           = 7;
	localparam int LAYERS         = 8;
	localparam int MODIFIER_SLOTS = 4;

	localparam int KEY_COUNT  = ROWS * COLS;
	localparam int STORE_SIZE = LAYERS * KEY_COUNT;

	localparam int KEY_W    = 28;
	localparam int IDX_W    = 5;
	localparam int KEY_PAD  = (1 << IDX_W) - KEY_COUNT;
	localparam int ADDR_W   = 8;
	localparam int CODE_W   = 8;
	localparam int PSUM_W   = 8;
	localparam int SUM_W    = 4;
	localparam int LAYER_W  = 3;
	localparam int COUNT_W  = 3;
	localparam int SLOT_W   = 2;
	localparam int TOTAL_W  = PSUM_W + 1;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SCAN = 1'b1;

	typedef enum logic [1:0] {
		KIND_STATUS  = 2'd0,
		KIND_RELALL  = 2'd1,
		KIND_PRESS   = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_PRIMARY   = 3'd0,
		REG_LIMIT     = 3'd1,
		REG_MOD_COUNT = 3'd2,
		REG_MOD_A     = 3'd3,
		REG_MOD_B     = 3'd4,
		REG_MOD_C     = 3'd5,
		REG_MOD_D     = 3'd6
	} reg_idx_t;

endpackage

### src/kmce_keymap.sv
// kmce_keymap: layered keymap store, one write port and one registered
// read port. Uses kmce_pkg for sizes.
module kmce_keymap (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [kmce_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [kmce_pkg::CODE_W-1:0]  wr_data,
	input  logic [kmce_pkg::ADDR_W-1:0]  rd_addr,
	output logic [kmce_pkg::CODE_W-1:0]  rd_data
);

	logic [kmce_pkg::CODE_W-1:0] mem [kmce_pkg::STORE_SIZE];
	logic [kmce_pkg::CODE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### src/key_matrix_change_encoder_top.sv
// key_matrix_change_encoder_top: scan frame sequencer, APB register bank
// and output register. Depends on kmce_pkg and kmce_keymap.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid/in_ready   | op, key_bits, partner_modifier_sum,
//          |                     | table_address, table_keycode
//  out     | out_valid/out_ready | kind, keycode, key_index, local_modifier_sum,
//          |                     | layer, last
//  cfg     | APB psel/penable    | paddr, pwdata, prdata (pready tied high)
//
// A load beat writes an in-range keymap entry when it is accepted. A scan
// frame forms the modifier sum one slot a cycle through the adder, sets the
// layer, sends a status beat and, if the layer fell on the primary side, a
// release-all beat, then walks the key positions up to the last changed key
// with one keymap read per changed key through the single read port, and
// then retires. Output stalls stretch the frame.
// Reset is asynchronous (arst_n low); the keymap has no clearing pass and
// must be loaded before its entries are used.
module key_matrix_change_encoder_top (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [kmce_pkg::APB_AW-1:0]    paddr,
	input  logic [kmce_pkg::APB_DW-1:0]    pwdata,
	output logic [kmce_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [kmce_pkg::KEY_W-1:0]     key_bits,
	input  logic [kmce_pkg::PSUM_W-1:0]    partner_modifier_sum,
	input  logic [kmce_pkg::ADDR_W-1:0]    table_address,
	input  logic [kmce_pkg::CODE_W-1:0]    table_keycode,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     kind,
	output logic [kmce_pkg::CODE_W-1:0]    keycode,
	output logic [kmce_pkg::IDX_W-1:0]     key_index,
	output logic [kmce_pkg::SUM_W-1:0]     local_modifier_sum,
	output logic [kmce_pkg::LAYER_W-1:0]   layer,
	output logic                           last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_LAYER,
		ST_STATUS,
		ST_RELALL,
		ST_SCAN,
		ST_READ
	} state_t;

	// ---------------- configuration registers ----------------
	logic                           primary_q;
	logic [kmce_pkg::LAYER_W-1:0]   limit_q;
	logic [kmce_pkg::COUNT_W-1:0]   mod_count_q;
	logic [kmce_pkg::IDX_W-1:0]     mod_key_q [kmce_pkg::MODIFIER_SLOTS];

	logic                 cfg_wr;
	kmce_pkg::reg_idx_t   cfg_idx;

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = kmce_pkg::reg_idx_t'(paddr[kmce_pkg::APB_AW-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_q   <= 1'b1;
			limit_q     <= kmce_pkg::LAYER_W'(3);
			mod_count_q <= kmce_pkg::COUNT_W'(2);
			for (int i = 0; i < kmce_pkg::MODIFIER_SLOTS; i++) begin
				mod_key_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			case (cfg_idx)
				kmce_pkg::REG_PRIMARY:   primary_q   <= pwdata[0];
				kmce_pkg::REG_LIMIT:     limit_q     <= pwdata[kmce_pkg::LAYER_W-1:0];
				kmce_pkg::REG_MOD_COUNT: mod_count_q <= pwdata[kmce_pkg::COUNT_W-1:0];
				kmce_pkg::REG_MOD_A:     mod_key_q[0] <= pwdata[kmce_pkg::IDX_W-1:0];
				kmce_pkg::REG_MOD_B:     mod_key_q[1] <= pwdata[kmce_pkg::IDX_W-1:0];
				kmce_pkg::REG_MOD_C:     mod_key_q[2] <= pwdata[kmce_pkg::IDX_W-1:0];
				kmce_pkg::REG_MOD_D:     mod_key_q[3] <= pwdata[kmce_pkg::IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			kmce_pkg::REG_PRIMARY:   prdata[0] = primary_q;
			kmce_pkg::REG_LIMIT:     prdata[kmce_pkg::LAYER_W-1:0] = limit_q;
			kmce_pkg::REG_MOD_COUNT: prdata[kmce_pkg::COUNT_W-1:0] = mod_count_q;
			kmce_pkg::REG_MOD_A:     prdata[kmce_pkg::IDX_W-1:0] = mod_key_q[0];
			kmce_pkg::REG_MOD_B:     prdata[kmce_pkg::IDX_W-1:0] = mod_key_q[1];
			kmce_pkg::REG_MOD_C:     prdata[kmce_pkg::IDX_W-1:0] = mod_key_q[2];
			kmce_pkg::REG_MOD_D:     prdata[kmce_pkg::IDX_W-1:0] = mod_key_q[3];
			default:                 prdata = '0;
		endcase
	end

	// ---------------- frame state ----------------
	state_t                         state_q;
	logic [kmce_pkg::KEY_W-1:0]     keys_q;      // keys of the frame in work
	logic [kmce_pkg::KEY_W-1:0]     prev_q;      // keys of the previous frame
	logic [kmce_pkg::KEY_W-1:0]     changed_q;   // changed keys still to report
	logic [kmce_pkg::PSUM_W-1:0]    psum_q;
	logic [kmce_pkg::SUM_W-1:0]     lsum_q;
	logic [kmce_pkg::COUNT_W-1:0]   slot_q;
	logic [kmce_pkg::LAYER_W-1:0]   layer_q;
	logic [kmce_pkg::LAYER_W-1:0]   cur_layer_q; // layer left by the last frame
	logic                           drop_q;      // layer fell on primary side
	logic [kmce_pkg::ADDR_W-1:0]    base_q;      // layer * KEY_COUNT
	logic [kmce_pkg::IDX_W-1:0]     k_q;

	// output register
	logic                           out_valid_q;
	kmce_pkg::kind_t                kind_q;
	logic [kmce_pkg::CODE_W-1:0]    keycode_q;
	logic [kmce_pkg::IDX_W-1:0]     key_index_q;
	logic [kmce_pkg::SUM_W-1:0]     out_sum_q;
	logic [kmce_pkg::LAYER_W-1:0]   out_layer_q;
	logic                           last_q;

	logic                           in_acc;
	logic                           can_load;
	logic                           out_load;
	logic [kmce_pkg::COUNT_W-1:0]   used;
	logic [kmce_pkg::IDX_W-1:0]     sel_key;
	logic [kmce_pkg::KEY_W+kmce_pkg::KEY_PAD-1:0] keys_pad;
	logic                           mod_hit;
	logic [kmce_pkg::TOTAL_W-1:0]   total;
	logic [kmce_pkg::LAYER_W-1:0]   layer_new;
	logic [kmce_pkg::KEY_W-1:0]     rest_after;
	logic                           mem_wr;
	logic [kmce_pkg::ADDR_W-1:0]    rd_addr;
	logic [kmce_pkg::CODE_W-1:0]    rd_data;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign can_load = !out_valid_q || out_ready;

	// a beat enters the output register this cycle
	assign out_load = can_load && (state_q inside {ST_STATUS, ST_RELALL, ST_READ});

	// slot count clamped to the slots that exist
	assign used = (mod_count_q > kmce_pkg::COUNT_W'(kmce_pkg::MODIFIER_SLOTS)) ?
		kmce_pkg::COUNT_W'(kmce_pkg::MODIFIER_SLOTS) : mod_count_q;

	// keys beyond the matrix read as not pressed
	assign keys_pad = {{kmce_pkg::KEY_PAD{1'b0}}, keys_q};
	assign sel_key  = mod_key_q[slot_q[kmce_pkg::SLOT_W-1:0]];
	assign mod_hit  = keys_pad[sel_key];

	assign total     = kmce_pkg::TOTAL_W'(psum_q) + kmce_pkg::TOTAL_W'(lsum_q);
	assign layer_new = (total > kmce_pkg::TOTAL_W'(limit_q)) ?
		limit_q : total[kmce_pkg::LAYER_W-1:0];

	assign rest_after = changed_q & ~(kmce_pkg::KEY_W'(1) << k_q);

	assign mem_wr  = in_acc && (op == kmce_pkg::OP_LOAD) &&
		(table_address < kmce_pkg::ADDR_W'(kmce_pkg::STORE_SIZE));
	assign rd_addr = base_q + kmce_pkg::ADDR_W'(k_q);

	kmce_keymap u_keymap (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (table_address),
		.wr_data (table_keycode),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keys_q      <= '0;
			prev_q      <= '0;
			changed_q   <= '0;
			psum_q      <= '0;
			lsum_q      <= '0;
			slot_q      <= '0;
			layer_q     <= '0;
			cur_layer_q <= '0;
			drop_q      <= 1'b0;
			base_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= kmce_pkg::KIND_STATUS;
			keycode_q   <= '0;
			key_index_q <= '0;
			out_sum_q   <= '0;
			out_layer_q <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && (op == kmce_pkg::OP_SCAN)) begin
						keys_q    <= key_bits;
						changed_q <= key_bits ^ prev_q;
						prev_q    <= key_bits;
						psum_q    <= partner_modifier_sum;
						lsum_q    <= '0;
						slot_q    <= '0;
						k_q       <= '0;
						state_q   <= ST_MOD;
					end
				end

				// one modifier slot a cycle through the shared adder
				ST_MOD: begin
					if (slot_q >= used) begin
						state_q <= ST_LAYER;
					end else begin
						if (mod_hit) begin
							lsum_q <= lsum_q + kmce_pkg::SUM_W'(slot_q) + kmce_pkg::SUM_W'(1);
						end
						slot_q <= slot_q + kmce_pkg::COUNT_W'(1);
					end
				end

				ST_LAYER: begin
					layer_q     <= layer_new;
					drop_q      <= primary_q && (layer_new < cur_layer_q);
					cur_layer_q <= layer_new;
					base_q      <= kmce_pkg::ADDR_W'(layer_new) *
						kmce_pkg::ADDR_W'(kmce_pkg::KEY_COUNT);
					state_q     <= ST_STATUS;
				end

				ST_STATUS: begin
					if (can_load) begin
						kind_q      <= kmce_pkg::KIND_STATUS;
						keycode_q   <= '0;
						key_index_q <= '0;
						out_sum_q   <= lsum_q;
						out_layer_q <= layer_q;
						last_q      <= !drop_q && (changed_q == '0);
						if (drop_q) begin
							state_q <= ST_RELALL;
						end else if (changed_q != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end

				ST_RELALL: begin
					if (can_load) begin
						kind_q      <= kmce_pkg::KIND_RELALL;
						keycode_q   <= '0;
						key_index_q <= '0;
						out_sum_q   <= lsum_q;
						out_layer_q <= layer_q;
						last_q      <= (changed_q == '0);
						state_q     <= (changed_q != '0) ? ST_SCAN : ST_IDLE;
					end
				end

				// walk key positions; a changed key starts a keymap read
				ST_SCAN: begin
					if (changed_q == '0) begin
						state_q <= ST_IDLE;
					end else if (changed_q[k_q]) begin
						state_q <= ST_READ;
					end else begin
						k_q <= k_q + kmce_pkg::IDX_W'(1);
					end
				end

				ST_READ: begin
					if (can_load) begin
						kind_q         <= keys_q[k_q] ? kmce_pkg::KIND_PRESS :
							kmce_pkg::KIND_RELEASE;
						keycode_q      <= rd_data;
						key_index_q    <= k_q;
						out_sum_q      <= lsum_q;
						out_layer_q    <= layer_q;
						last_q         <= (rest_after == '0);
						changed_q[k_q] <= 1'b0;
						k_q            <= k_q + kmce_pkg::IDX_W'(1);
						state_q        <= ST_SCAN;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign kind               = kind_q;
	assign keycode            = keycode_q;
	assign key_index          = key_index_q;
	assign local_modifier_sum = out_sum_q;
	assign layer              = out_layer_q;
	assign last               = last_q;

`ifndef SYNTH
	// pending change set only shrinks while a frame is in work
	a_changed_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && $past(!in_ready)) |-> ((changed_q & ~$past(changed_q)) == '0))
		else $error("change set grew during a frame");

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(keycode)
			&& $stable(key_index) && $stable(last)))
		else $error("result beat changed while stalled");

	// release-all only from the primary half
	a_relall_primary: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == kmce_pkg::KIND_RELALL)) |-> primary_q)
		else $error("release-all on secondary side");

	// reported layer never exceeds the limit
	a_layer_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (layer <= limit_q))
		else $error("layer above limit");
`endif

endmodule
